FILE: rtl/gradient_noise_1d_defines.svh
// Assertion macros shared by the gradient noise RTL.
`ifndef GRADIENT_NOISE_1D_DEFINES_SVH
`define GRADIENT_NOISE_1D_DEFINES_SVH

// Property checked at every clock edge outside reset.
`define GN1D_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define GN1D_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/gn1d_pkg.sv
// Package with the types and constants of the gradient noise block.
package gn1d_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int TABLE_SIZE  = 256;
  localparam int IDX_W       = $clog2(TABLE_SIZE);
  localparam int POS_W       = 32;
  localparam int NOISE_W     = 18;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_EVAL = 1'b1
  } req_kind_t;

  typedef enum logic {
    REG_RANGE_MIN = 1'b0,
    REG_RANGE_MAX = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic                 is_eval;
    logic [IDX_W-1:0]     index;
    logic [FRAC_BITS-1:0] frac;
    logic                 sign_bit;
  } item_t;

  function automatic logic signed [39:0] fx_round(input logic signed [39:0] prod);
    return (prod + (40'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

endpackage

FILE: rtl/gradient_noise_1d.sv
// An accepted eval word passes the front queue and the back-end stage registers before its result shows on rsp_valid.
// Throughput: one word per cycle while rsp_stall is low, set by the fully pipelined fade and blend datapath.
// Load words produce no result; the front queue holds 4 words when the output stalls.
// Reset clears all valid bits and queue pointers and sets the range to -1.0 and +1.0.
// The gradient sign table is not cleared and must be loaded before use.
module gradient_noise_1d import gn1d_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  logic                      req_type,
  input  logic signed [POS_W-1:0]   position,
  input  logic [7:0]                table_index,
  input  logic                      table_bit,
  output logic                      rsp_valid,
  input  logic                      rsp_stall,
  output logic signed [NOISE_W-1:0] noise_value,
  output logic signed [31:0]        mapped_value
);

  logic signed [31:0] range_min;
  logic signed [31:0] range_max;
  item_t              head;
  logic               head_valid;
  logic               pop;
  cfg_reg_t           reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      range_min <= -32'sd65536;
      range_max <= 32'sd65536;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_sel)
        REG_RANGE_MIN: range_min <= pwdata;
        REG_RANGE_MAX: range_max <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_RANGE_MIN: prdata = range_min;
      REG_RANGE_MAX: prdata = range_max;
      default:       prdata = '0;
    endcase
  end

  gn1d_front u_front (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req_type    (req_type),
    .position    (position),
    .table_index (table_index),
    .table_bit   (table_bit),
    .head        (head),
    .head_valid  (head_valid),
    .pop         (pop)
  );

  gn1d_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .head_valid   (head_valid),
    .pop          (pop),
    .range_min    (range_min),
    .range_max    (range_max),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .noise_value  (noise_value),
    .mapped_value (mapped_value)
  );

endmodule

FILE: rtl/gn1d_ram.sv
// Generic RAM with one write port and two registered read ports.
module gn1d_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             rd_en,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

FILE: rtl/gn1d_front.sv
// Front end: classifies incoming words and queues them for the datapath.
`include "gradient_noise_1d_defines.svh"

module gn1d_front import gn1d_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    req_valid,
  output logic                    req_stall,
  input  logic                    req_type,
  input  logic signed [POS_W-1:0] position,
  input  logic [7:0]              table_index,
  input  logic                    table_bit,
  output item_t                   head,
  output logic                    head_valid,
  input  logic                    pop
);

  item_t              entries [QUEUE_DEPTH];
  item_t              incoming;
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               push;

  assign req_stall  = (count == QCNT_W'(QUEUE_DEPTH));
  assign push       = req_valid && !req_stall;
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  always_comb begin
    incoming.is_eval  = (req_kind_t'(req_type) == REQ_EVAL);
    incoming.frac     = position[FRAC_BITS-1:0];
    incoming.sign_bit = table_bit;
    if (incoming.is_eval) begin
      // The low bits of floor(x) give the table index modulo its size.
      incoming.index = position[FRAC_BITS+IDX_W-1:FRAC_BITS];
    end else begin
      incoming.index = table_index[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  `GN1D_ASSERT(a_count_bound, count <= QCNT_W'(QUEUE_DEPTH), "Queue count exceeds its depth.")
  `GN1D_ASSERT_NEXT(a_count_track, 1'b1, count == $past(count) + QCNT_W'($past(push)) - QCNT_W'($past(pop)), "Queue count lost track of pushes and pops.")

endmodule

FILE: rtl/gn1d_back.sv
// Back end: table access, fade curve, gradient blend and range mapping pipeline.
`include "gradient_noise_1d_defines.svh"

module gn1d_back import gn1d_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  item_t                     head,
  input  logic                      head_valid,
  output logic                      pop,
  input  logic signed [31:0]        range_min,
  input  logic signed [31:0]        range_max,
  output logic                      rsp_valid,
  input  logic                      rsp_stall,
  output logic signed [NOISE_W-1:0] noise_value,
  output logic signed [31:0]        mapped_value
);

  localparam logic signed [39:0] ONE40   = 40'sd1 <<< FRAC_BITS;
  localparam logic signed [19:0] ONE20   = 20'sd1 <<< FRAC_BITS;
  localparam logic signed [17:0] ONE18   = 18'sd1 <<< FRAC_BITS;
  localparam logic [16:0]        ONE17   = 17'd1 << FRAC_BITS;
  localparam logic signed [52:0] OUT_MAX = 53'sd2147483647;
  localparam logic signed [52:0] OUT_MIN = -53'sd2147483648;

  logic adv;
  logic rd_sign_a;
  logic rd_sign_b;

  logic v1, v2, v3, v4, v5, v6, v7;

  logic [FRAC_BITS-1:0] d_1, d_2, d_3;
  logic [16:0]          d2_1;
  logic [20:0]          inner_1, inner_2;
  logic [16:0]          d3_2;
  logic [16:0]          f_3;
  logic                 sg0_2, sg0_3, sg0_4;
  logic                 sg1_2, sg1_3, sg1_4;
  logic signed [17:0]   t0_4, t1_4;
  logic signed [17:0]   n5, n6, n7;
  logic signed [51:0]   prod_6;
  logic signed [31:0]   m7;

  logic signed [39:0] d_ext, lin, prod_dd, prod_lin, rnd_dd, rnd_lin;
  logic signed [39:0] prod_d3, rnd_d3;
  logic signed [39:0] prod_f, rnd_f, f_clamped;
  logic [16:0]        one_minus_f;
  logic signed [39:0] d_ext3, prod_t0, prod_t1, rnd_t0, rnd_t1;
  logic signed [19:0] part0, part1, n_sum, n_clamped;
  logic signed [32:0] diff;
  logic [17:0]        nplus;
  logic signed [51:0] shifted;
  logic signed [52:0] m_sum;
  logic signed [31:0] m_sat;

  assign adv = !(v7 && rsp_stall);
  assign pop = head_valid && adv;

  gn1d_ram #(
    .WIDTH(1),
    .DEPTH(TABLE_SIZE)
  ) u_sign_ram (
    .clk     (clk),
    .we      (pop && !head.is_eval),
    .waddr   (head.index),
    .wdata   (head.sign_bit),
    .rd_en   (adv),
    .raddr_a (head.index),
    .raddr_b (head.index + IDX_W'(1)),
    .rdata_a (rd_sign_a),
    .rdata_b (rd_sign_b)
  );

  always_comb begin
    d_ext    = $signed({24'd0, head.frac});
    lin      = d_ext * 40'sd6 - (40'sd15 <<< FRAC_BITS);
    prod_dd  = d_ext * d_ext;
    prod_lin = d_ext * lin;
    rnd_dd   = fx_round(prod_dd);
    rnd_lin  = fx_round(prod_lin) + (40'sd10 <<< FRAC_BITS);

    prod_d3 = $signed({23'd0, d2_1}) * $signed({24'd0, d_1});
    rnd_d3  = fx_round(prod_d3);

    prod_f = $signed({23'd0, d3_2}) * $signed({19'd0, inner_2});
    rnd_f  = fx_round(prod_f);
    if (rnd_f < 40'sd0) begin
      f_clamped = 40'sd0;
    end else if (rnd_f > ONE40) begin
      f_clamped = ONE40;
    end else begin
      f_clamped = rnd_f;
    end

    one_minus_f = ONE17 - f_3;
    d_ext3      = $signed({24'd0, d_3});
    prod_t0     = $signed({23'd0, one_minus_f}) * d_ext3;
    prod_t1     = $signed({23'd0, f_3}) * (d_ext3 - ONE40);
    rnd_t0      = fx_round(prod_t0);
    rnd_t1      = fx_round(prod_t1);

    part0 = sg0_4 ? 20'(t0_4) : -20'(t0_4);
    part1 = sg1_4 ? 20'(t1_4) : -20'(t1_4);
    n_sum = part0 + part1;
    if (n_sum > ONE20) begin
      n_clamped = ONE20;
    end else if (n_sum < -ONE20) begin
      n_clamped = -ONE20;
    end else begin
      n_clamped = n_sum;
    end

    diff  = 33'(range_max) - 33'(range_min);
    nplus = unsigned'(n5 + ONE18);

    shifted = (prod_6 + (52'sd1 <<< FRAC_BITS)) >>> (FRAC_BITS + 1);
    m_sum   = 53'(shifted) + 53'(range_min);
    if (m_sum > OUT_MAX) begin
      m_sat = OUT_MAX[31:0];
    end else if (m_sum < OUT_MIN) begin
      m_sat = OUT_MIN[31:0];
    end else begin
      m_sat = m_sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_1     <= head.frac;
      d2_1    <= rnd_dd[16:0];
      inner_1 <= rnd_lin[20:0];

      d_2     <= d_1;
      inner_2 <= inner_1;
      d3_2    <= rnd_d3[16:0];
      sg0_2   <= rd_sign_a;
      sg1_2   <= rd_sign_b;

      d_3   <= d_2;
      f_3   <= f_clamped[16:0];
      sg0_3 <= sg0_2;
      sg1_3 <= sg1_2;

      t0_4  <= rnd_t0[17:0];
      t1_4  <= rnd_t1[17:0];
      sg0_4 <= sg0_3;
      sg1_4 <= sg1_3;

      n5 <= n_clamped[17:0];

      n6     <= n5;
      prod_6 <= 52'(diff) * $signed({34'd0, nplus});

      n7 <= n6;
      m7 <= m_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else if (adv) begin
      v1 <= head_valid && head.is_eval;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
    end
  end

  assign rsp_valid    = v7;
  assign noise_value  = n7;
  assign mapped_value = m7;

  `GN1D_ASSERT_NEXT(a_pipe_freeze, !adv, $stable(v1) && $stable(v2) && $stable(v3) && $stable(v6), "Pipeline moved while the output was stalled.")
  `GN1D_ASSERT(a_noise_range, v6 |-> (n6 >= -ONE18) && (n6 <= ONE18), "Noise left the range from minus one to one.")

endmodule

FILE: bench/gradient_noise_1d_test.sv
// Self-checking testbench for the one-dimensional gradient noise block.
module gradient_noise_1d_test import gn1d_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES  = 80;
  localparam int SETTLE_WAIT  = 12;
  localparam int DRAIN_LIMIT  = 5000;

  typedef struct packed {
    logic signed [NOISE_W-1:0] noise;
    logic signed [31:0]        mapped;
  } noise_word_t;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PATTERN, STALL_HEAVY} stall_style_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [2:0]                paddr = '0;
  logic [31:0]               pwdata = '0;
  logic [31:0]               prdata;
  logic                      pready;
  logic                      req_valid = 1'b0;
  logic                      req_stall;
  logic                      req_type = 1'b0;
  logic signed [POS_W-1:0]   position = '0;
  logic [7:0]                table_index = '0;
  logic                      table_bit = 1'b0;
  logic                      rsp_valid;
  logic                      rsp_stall = 1'b0;
  logic signed [NOISE_W-1:0] noise_value;
  logic signed [31:0]        mapped_value;

  bit           grad_sign [TABLE_SIZE];
  longint       range_lo = -65536;
  longint       range_hi = 65536;
  noise_word_t  expected_noise [$];
  int           fail_count = 0;
  int           words_sent = 0;
  int           results_checked = 0;
  int           settings_used = 1;
  int           burst_left = 0;
  bit           steady_sender = 1'b0;
  stall_style_t stall_style = STALL_NONE;
  int           hold_serial = 0;
  int           hold_served = 0;
  int           hold_left = 0;
  logic [7:0]   stall_tick = '0;

  gradient_noise_1d u_top (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .req_valid(req_valid), .req_stall(req_stall), .req_type(req_type),
    .position(position), .table_index(table_index), .table_bit(table_bit),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .noise_value(noise_value), .mapped_value(mapped_value)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint fx_product(longint a, longint b);
    return (a * b + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  function automatic noise_word_t blend_noise(logic signed [POS_W-1:0] pos);
    longint unit, x, p, q, d, d2, d3, inner, fade, n, m, g0, g1;
    noise_word_t w;
    unit = longint'(1) <<< FRAC_BITS;
    x = pos;
    p = x >>> FRAC_BITS;
    q = p + 1;
    d = x - p * unit;
    d2 = fx_product(d, d);
    d3 = fx_product(d2, d);
    inner = fx_product(d, 6 * d - 15 * unit) + 10 * unit;
    fade = fx_product(d3, inner);
    if (fade < 0) fade = 0;
    if (fade > unit) fade = unit;
    g0 = grad_sign[p[IDX_W-1:0]] ? 1 : -1;
    g1 = grad_sign[q[IDX_W-1:0]] ? 1 : -1;
    n = g0 * fx_product(unit - fade, d) + g1 * fx_product(fade, d - unit);
    if (n > unit) n = unit;
    if (n < -unit) n = -unit;
    m = range_lo + (((range_hi - range_lo) * (n + unit) + unit) >>> (FRAC_BITS + 1));
    if (m > 64'sd2147483647) m = 64'sd2147483647;
    if (m < -64'sd2147483648) m = -64'sd2147483648;
    w.noise = n[NOISE_W-1:0];
    w.mapped = m[31:0];
    return w;
  endfunction

  function automatic logic [31:0] random_position();
    logic [15:0] frac;
    int whole;
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: begin
        whole = $urandom_range(0, 1023) - 512;
        frac = 16'($urandom);
        return {whole[15:0], frac};
      end
      2: begin
        whole = $urandom;
        case ($urandom_range(0, 3))
          0: frac = 16'h0000;
          1: frac = 16'h0001;
          2: frac = 16'hFFFF;
          default: frac = 16'h8000;
        endcase
        return {whole[15:0], frac};
      end
      default: begin
        whole = $urandom_range(0, 255);
        frac = 16'($urandom);
        return {whole[15:0], frac};
      end
    endcase
  endfunction

  // The receiver stalls on its own pattern; a requested hold-off overrides it.
  always @(posedge clk) begin
    stall_tick <= stall_tick + 8'd1;
    if (hold_serial != hold_served) begin
      hold_served <= hold_serial;
      hold_left <= HOLD_CYCLES;
      rsp_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rsp_stall <= 1'b1;
    end else begin
      case (stall_style)
        STALL_RANDOM: rsp_stall <= ($urandom_range(0, 2) == 0);
        STALL_PATTERN: rsp_stall <= (stall_tick[2:0] < 3'd3);
        STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
        default: rsp_stall <= 1'b0;
      endcase
    end
  end

  always @(posedge clk) begin
    noise_word_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_noise.size() == 0) begin
        $error("noise word arrived with none expected: noise_value %0d mapped_value %0d",
               noise_value, mapped_value);
        fail_count++;
      end else begin
        want = expected_noise.pop_front();
        results_checked++;
        if (noise_value !== want.noise) begin
          $error("noise_value: expected %0d, got %0d", want.noise, noise_value);
          fail_count++;
        end
        if (mapped_value !== want.mapped) begin
          $error("mapped_value: expected %0d, got %0d", want.mapped, mapped_value);
          fail_count++;
        end
      end
    end
  end

  task automatic send_word(req_kind_t kind, logic [31:0] pos, logic [7:0] idx, logic grad_bit);
    req_valid <= 1'b1;
    req_type <= kind;
    position <= pos;
    table_index <= idx;
    table_bit <= grad_bit;
    do @(posedge clk); while (req_stall);
    words_sent++;
    if (kind == REQ_EVAL) expected_noise.push_back(blend_noise(pos));
    else grad_sign[idx] = grad_bit;
    if (!steady_sender) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(0, 15);
        req_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  endtask

  task automatic send_random_word(int eval_pct);
    if ($urandom_range(0, 99) < eval_pct) begin
      send_word(REQ_EVAL, random_position(), 8'($urandom), 1'($urandom));
    end else begin
      send_word(REQ_LOAD, $urandom, 8'($urandom), 1'($urandom));
    end
  endtask

  task automatic wait_results_drained();
    req_valid <= 1'b0;
    do @(posedge clk); while (expected_noise.size() != 0);
  endtask

  task automatic write_register(cfg_reg_t which, logic [31:0] value);
    wait_results_drained();
    repeat (SETTLE_WAIT) @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {which, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (which)
      REG_RANGE_MIN: range_lo = longint'(signed'(value));
      default: range_hi = longint'(signed'(value));
    endcase
  endtask

  task automatic load_gradient_table();
    int i;
    for (i = 0; i < TABLE_SIZE; i++) send_word(REQ_LOAD, $urandom, i[7:0], 1'($urandom));
  endtask

  task automatic test_edge_positions();
    send_word(REQ_LOAD, $urandom, 8'd0, 1'b1);
    send_word(REQ_LOAD, $urandom, 8'd1, 1'b1);
    send_word(REQ_LOAD, $urandom, 8'd2, 1'b0);
    send_word(REQ_LOAD, $urandom, 8'd3, 1'b0);
    send_word(REQ_LOAD, $urandom, 8'd255, 1'b0);
    // The four sign pairings, then the wrap of the table index in both directions and edge values of the fraction.
    send_word(REQ_EVAL, 32'h00FF_8000, 8'($urandom), 1'($urandom));
    send_word(REQ_EVAL, 32'h0000_4000, 8'($urandom), 1'($urandom));
    send_word(REQ_EVAL, 32'h0001_C000, 8'($urandom), 1'($urandom));
    send_word(REQ_EVAL, 32'h0002_8000, 8'($urandom), 1'($urandom));
    send_word(REQ_EVAL, 32'hFFFF_8000, 8'($urandom), 1'($urandom));
    send_word(REQ_EVAL, 32'h7FFF_FFFF, 8'($urandom), 1'($urandom));
    send_word(REQ_EVAL, 32'h8000_0000, 8'($urandom), 1'($urandom));
    send_word(REQ_EVAL, 32'hFFFF_FFFF, 8'($urandom), 1'($urandom));
    send_word(REQ_EVAL, 32'h0000_0000, 8'($urandom), 1'($urandom));
    send_word(REQ_EVAL, 32'h0000_0001, 8'($urandom), 1'($urandom));
    send_word(REQ_EVAL, 32'h0000_FFFF, 8'($urandom), 1'($urandom));
    send_word(REQ_EVAL, 32'h0001_0000, 8'($urandom), 1'($urandom));
    send_word(REQ_EVAL, 32'h0000_8000, 8'($urandom), 1'($urandom));
  endtask

  task automatic test_range_settings();
    logic [31:0] lo, hi;
    int s;
    for (s = 0; s < 7; s++) begin
      case (s)
        0: begin lo = 32'h8000_0000; hi = 32'h7FFF_FFFF; end
        1: begin lo = 32'h7FFF_FFFF; hi = 32'h8000_0000; end
        2: begin lo = 32'h0000_0000; hi = 32'h0000_0000; end
        3: begin lo = 32'h7FFF_FFFF; hi = 32'h7FFF_FFFF; end
        4: begin lo = 32'h0001_0000; hi = 32'hFFFF_0000; end
        5: begin lo = $urandom; hi = $urandom; end
        default: begin lo = 32'hFFFF_0000; hi = 32'h0001_0000; end
      endcase
      write_register(REG_RANGE_MIN, lo);
      write_register(REG_RANGE_MAX, hi);
      settings_used++;
      stall_style = stall_style_t'($urandom_range(0, 3));
      repeat (35) send_random_word(85);
    end
    stall_style = STALL_NONE;
  endtask

  task automatic test_backpressure();
    int i;
    steady_sender = 1'b1;
    hold_serial <= hold_serial + 1;
    for (i = 0; i < 40; i++) send_word(REQ_EVAL, random_position(), 8'($urandom), 1'($urandom));
    wait_results_drained();
    hold_serial <= hold_serial + 1;
    for (i = 0; i < 30; i++) send_random_word(60);
    wait_results_drained();
    steady_sender = 1'b0;
  endtask

  task automatic test_random_traffic();
    int i;
    for (i = 0; i < 520; i++) begin
      if (i % 100 == 0) begin
        stall_style = stall_style_t'($urandom_range(0, 3));
        steady_sender = ($urandom_range(0, 3) == 0);
      end
      if (i == 400) begin
        write_register(REG_RANGE_MIN, $urandom);
        write_register(REG_RANGE_MAX, $urandom);
        settings_used++;
      end
      send_random_word(70);
    end
    steady_sender = 1'b0;
    stall_style = STALL_NONE;
  endtask

  task automatic finish_run();
    int waited;
    req_valid <= 1'b0;
    waited = 0;
    while (expected_noise.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    if (expected_noise.size() != 0) begin
      $error("%0d expected noise words never arrived", expected_noise.size());
      fail_count++;
    end
    $display("Sent %0d words over %0d output range settings; checked %0d noise results.",
             words_sent, settings_used, results_checked);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    load_gradient_table();
    test_edge_positions();
    test_range_settings();
    test_backpressure();
    test_random_traffic();
    finish_run();
  end

  initial begin
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

FILE: gradient_noise_1d.f
+incdir+rtl
rtl/gn1d_pkg.sv
rtl/gn1d_ram.sv
rtl/gn1d_front.sv
rtl/gn1d_back.sv
rtl/gradient_noise_1d.sv
bench/gradient_noise_1d_test.sv
